### hdl/lrupr_pkg.sv
package lrupr_pkg;

   // Field widths of the transfer items
   localparam int PID_W   = 5;
   localparam int PC_W    = 12;
   localparam int MASK_W  = 32;
   localparam int COUNT_W = 6;
   localparam int PAGE_W  = 5;
   localparam int STAMP_W = 32;

   typedef struct packed {
      logic [PID_W-1:0]   process_id;
      logic               active;
      logic [PC_W-1:0]    program_counter;
      logic [MASK_W-1:0]  resident_mask;
      logic [COUNT_W-1:0] page_count;
      logic               frame_free;
      logic               end_of_tick;
   } req_item_type;

   typedef struct packed {
      logic [PAGE_W-1:0] wanted_page;
      logic              pagein_request;
      logic              evict_valid;
      logic [PAGE_W-1:0] evict_page;
      logic              no_victim;
   } rsp_item_type;

   // Control from the sequencer to the shared compare unit
   typedef struct packed {
      logic clear;
      logic cand_valid;
   } cmp_ctrl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_EVICT,
      ST_STAMP,
      ST_DONE
   } seq_state_type;

endpackage

### hdl/lrupr_stamp_mem.sv
module lrupr_stamp_mem
   import lrupr_pkg::*;
#(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [STAMP_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [STAMP_W-1:0] rd_data
);

   logic [STAMP_W-1:0] mem [DEPTH];
   logic [STAMP_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/lrupr_min_cmp.sv
module lrupr_min_cmp
   import lrupr_pkg::*;
#(
   parameter int IDX_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  cmp_ctrl_type       ctrl,
   input  logic [IDX_W-1:0]   cand_page,
   input  logic [STAMP_W-1:0] cand_stamp,
   output logic               found,
   output logic [IDX_W-1:0]   best_page
);

   logic               found_ff;
   logic               found_in;
   logic [IDX_W-1:0]   best_page_ff;
   logic [IDX_W-1:0]   best_page_in;
   logic [STAMP_W-1:0] best_stamp_ff;
   logic [STAMP_W-1:0] best_stamp_in;
   logic               take;

   // Strictly older wins, so the lowest page keeps a tie
   assign take = ctrl.cand_valid && (!found_ff || (cand_stamp < best_stamp_ff));

   always_comb begin
      found_in      = found_ff;
      best_page_in  = best_page_ff;
      best_stamp_in = best_stamp_ff;
      if (ctrl.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in      = 1'b1;
         best_page_in  = cand_page;
         best_stamp_in = cand_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_page_ff  <= best_page_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign found     = found_ff;
   assign best_page = best_page_ff;

endmodule

### hdl/lru_page_replacement_top.sv
// LRU page replacement with per-page timestamps. Pulse start while busy is low to hand
// over one process item; exactly one result follows on rsp_item, marked by rsp_strobe for
// one cycle, and must be taken then since the block cannot be held off. An item that needs
// no victim search goes from the check through the stamp write to the result, or straight from
// the check to the result when the process is inactive or out of range. An item that must evict
// walks the stamp memory one page per cycle through a single read port and one shared
// compare unit, then evicts the oldest resident page if any, stamps the wanted page and gives
// the result. busy drops while the result is on the ports, so the next item can be taken at
// the edge that takes the result. After reset the block clears its PROCESSES*PAGES stamp
// entries one per cycle and holds busy high until done.
module lru_page_replacement_top
   import lrupr_pkg::*;
#(
   parameter int PROCESSES = 32,
   parameter int PAGES     = 32,
   parameter int PAGE_SIZE = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   localparam int DEPTH    = PROCESSES * PAGES;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(PAGES + 1);
   localparam int IDX_W    = $clog2(PAGES);
   // Page = pc / PAGE_SIZE as a multiply by a rounded-up reciprocal, exact for 12-bit pc
   localparam int RECIP_SH = 24;
   localparam int RECIP_W  = RECIP_SH + 1;
   localparam longint RECIP = ((64'd1 << RECIP_SH) + PAGE_SIZE - 1) / PAGE_SIZE;
   localparam int PROD_W   = PC_W + RECIP_W;

   seq_state_type      state_ff, state_in;
   req_item_type       item_ff, item_in;
   logic [PC_W-1:0]    want_ff, want_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [CNT_W-1:0]   npg_ff, npg_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]   rd_page_ff, rd_page_in;
   logic               pagein_ff, pagein_in;
   logic               evict_ff, evict_in;
   logic [PAGE_W-1:0]  evpg_ff, evpg_in;
   logic               novic_ff, novic_in;
   logic [STAMP_W-1:0] tick_ff, tick_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic               accept;
   logic [PROD_W-1:0]  prod;
   logic               hit;
   logic               want_res;
   logic               issue_res;
   logic [MASK_W-1:0]  mask_want_sh;
   logic [MASK_W-1:0]  mask_issue_sh;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [STAMP_W-1:0] wr_data;
   logic [ADDR_W-1:0]  rd_addr;
   logic [STAMP_W-1:0] rd_data;
   cmp_ctrl_type       cmp_ctrl;
   logic               found;
   logic [IDX_W-1:0]   best_page;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   assign prod = PROD_W'(req_item.program_counter) * PROD_W'(RECIP);

   // Residency of the wanted page and of the page being issued; shifts past 31 give zero
   assign mask_want_sh  = item_ff.resident_mask >> want_ff;
   assign mask_issue_sh = item_ff.resident_mask >> issue_ff;
   assign want_res      = mask_want_sh[0];
   assign issue_res     = mask_issue_sh[0];

   assign hit = item_ff.active && (int'(item_ff.process_id) < PROCESSES)
                && (int'(want_ff) < PAGES);

   lrupr_stamp_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lrupr_min_cmp #(
      .IDX_W (IDX_W)
   ) u_cmp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cmp_ctrl),
      .cand_page  (rd_page_ff),
      .cand_stamp (rd_data),
      .found      (found),
      .best_page  (best_page)
   );

   // Sequencer: next state, memory commands and result assembly
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      want_in      = want_ff;
      base_in      = base_ff;
      npg_in       = npg_ff;
      issue_in     = issue_ff;
      rd_valid_in  = 1'b0;
      rd_page_in   = rd_page_ff;
      pagein_in    = pagein_ff;
      evict_in     = evict_ff;
      evpg_in      = evpg_ff;
      novic_in     = novic_ff;
      tick_in      = tick_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_addr      = base_ff + ADDR_W'(issue_ff);
      cmp_ctrl.clear      = 1'b0;
      cmp_ctrl.cand_valid = rd_valid_ff;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_item;
               want_in = prod[RECIP_SH +: PC_W];
               base_in = ADDR_W'(ADDR_W'(req_item.process_id) * ADDR_W'(PAGES));
               if (int'(req_item.page_count) > PAGES) begin
                  npg_in = CNT_W'(PAGES);
               end else begin
                  npg_in = CNT_W'(req_item.page_count);
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            pagein_in      = hit && !want_res && item_ff.frame_free;
            evict_in       = 1'b0;
            evpg_in        = '0;
            novic_in       = 1'b0;
            issue_in       = '0;
            cmp_ctrl.clear = 1'b1;
            if (!hit) begin
               state_in = ST_DONE;
            end else if (want_res || item_ff.frame_free) begin
               state_in = ST_STAMP;
            end else begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // Issue one read per page; the compare sees it in the next cycle, for resident pages only
            if (issue_ff < npg_ff) begin
               rd_valid_in = issue_res;
               rd_page_in  = IDX_W'(issue_ff);
               issue_in    = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_EVICT;
            end
         end
         ST_EVICT: begin
            if (found) begin
               wr_en    = 1'b1;
               wr_addr  = base_ff + ADDR_W'(best_page);
               wr_data  = '0;
               evict_in = 1'b1;
               evpg_in  = PAGE_W'(best_page);
            end else begin
               novic_in = 1'b1;
            end
            state_in = ST_STAMP;
         end
         ST_STAMP: begin
            wr_en    = 1'b1;
            wr_addr  = base_ff + ADDR_W'(want_ff);
            wr_data  = tick_ff;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid_in               = 1'b1;
            rsp_item_in.wanted_page    = want_ff[PAGE_W-1:0];
            rsp_item_in.pagein_request = pagein_ff;
            rsp_item_in.evict_valid    = evict_ff;
            rsp_item_in.evict_page     = evpg_ff;
            rsp_item_in.no_victim      = novic_ff;
            if (item_ff.end_of_tick) begin
               tick_in = tick_ff + STAMP_W'(1);
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         tick_ff      <= STAMP_W'(1);
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         tick_ff      <= tick_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      want_ff     <= want_in;
      base_ff     <= base_in;
      npg_ff      <= npg_in;
      issue_ff    <= issue_in;
      rd_page_ff  <= rd_page_in;
      pagein_ff   <= pagein_in;
      evict_ff    <= evict_in;
      evpg_ff     <= evpg_in;
      novic_ff    <= novic_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_item_ff;

endmodule
